// ----- sv/tsra_pkg.sv -----
// ----------------------------------------------------------------------------
// tsra_pkg: shared types and constants for the sample ring averager
// Holds the RAM word layout, the lane control struct and the control states.
// ----------------------------------------------------------------------------
package tsra_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TIME_W   = 32;
	localparam int NUM_AXES = 3;
	localparam int USED_W   = 5;
	// RAM word: x in [15:0], y in [31:16], z in [47:32], time in [79:48]
	localparam int TIME_LSB = NUM_AXES * SAMPLE_W;
	localparam int WORD_W   = TIME_LSB + TIME_W;

	localparam logic OP_PUSH     = 1'b0;
	localparam logic OP_ESTIMATE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clear;
		logic accum;
		logic div_start;
	} lane_ctl_t;

endpackage

// ----- sv/timestamped_sample_ring_average_unit.sv -----
// ----------------------------------------------------------------------------
// Push: accept goes to the finish state, which loads the output register.
// Estimate: ring walk from the newest slot (one RAM read per cycle), then a bit-serial
// divide of SUM_W = 17 + clog2(DEPTH) bits, then finish; no divide if nothing visited.
// One transaction at a time; the input is open whenever the sequencer is idle,
// also while a result waits in the output register.
// Reset clears the write pointer, fill count, last estimate time and valids, not the RAM.
// ----------------------------------------------------------------------------
// timestamped_sample_ring_average_unit: ring buffer moving average
// Stores timestamped three-axis samples and averages the recent ones.
// ----------------------------------------------------------------------------
module timestamped_sample_ring_average_unit #(
	parameter int DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input transaction
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] mag_x,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] mag_y,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] mag_z,
	input  logic [tsra_pkg::TIME_W-1:0]         timestamp,
	// result transaction
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tsra_pkg::SAMPLE_W-1:0] avg_x,
	output logic signed [tsra_pkg::SAMPLE_W-1:0] avg_y,
	output logic signed [tsra_pkg::SAMPLE_W-1:0] avg_z,
	output logic [tsra_pkg::USED_W-1:0]         samples_used,
	output logic                                updated,
	output logic [tsra_pkg::TIME_W-1:0]         estimate_time
);

	import tsra_pkg::*;

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// ---------------- control state ----------------
	state_t state_q, state_d;

	logic [AW-1:0]     ws_q;        // next slot to write
	logic [CNT_W-1:0]  fill_q;      // filled entries, saturating at DEPTH
	logic [TIME_W-1:0] last_est_q;  // time of the last formed estimate
	logic              out_valid_q;

	// walk bookkeeping
	logic [AW-1:0]     rd_ptr_q;    // slot of the next read
	logic [CNT_W-1:0]  issued_q;    // reads issued so far
	logic              rd_pend_s1;  // RAM data for an issued read is present
	logic              stop_q;      // walk hit an entry older than last estimate
	logic [CNT_W-1:0]  n_q;         // samples accumulated

	// item held for the result
	logic              op_q;
	logic [TIME_W-1:0] now_q;

	// ---------------- RAM ----------------
	logic [WORD_W-1:0] wr_word;
	logic [WORD_W-1:0] rd_word;
	logic [TIME_W-1:0] rd_time;
	logic              ram_we;

	// ---------------- lanes ----------------
	lane_ctl_t                   lane_ctl;
	logic [NUM_AXES-1:0]         lane_busy;
	logic signed [SAMPLE_W-1:0]  lane_avg [NUM_AXES];

	// ---------------- control signals ----------------
	logic accept;
	logic hit;
	logic take;
	logic issue;
	logic walk_end;
	logic out_free;
	logic load_out;
	logic est_ok;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign est_ok   = (op_q == OP_ESTIMATE) && (n_q != '0);

	assign wr_word = {timestamp, mag_z, mag_y, mag_x};
	assign rd_time = rd_word[TIME_LSB +: TIME_W];
	assign ram_we  = accept && (op == OP_PUSH);

	tsra_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ws_q),
		.wdata (wr_word),
		.raddr (rd_ptr_q),
		.rdata (rd_word)
	);

	// Walk data checks: an entry older than the last estimate ends the walk,
	// anything else is summed into all three lanes.
	always_comb begin
		hit      = rd_pend_s1 && !stop_q && (rd_time < last_est_q);
		take     = rd_pend_s1 && !stop_q && !hit;
		issue    = (state_q == ST_WALK) && !stop_q && !hit && (issued_q < fill_q);
		walk_end = stop_q || ((issued_q == fill_q) && !rd_pend_s1);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		lane_ctl = '0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					lane_ctl.clear = 1'b1;
					state_d = (op == OP_PUSH) ? ST_FIN : ST_WALK;
				end
			end
			ST_WALK: begin
				lane_ctl.accum = take;
				if (walk_end) begin
					if (n_q != '0) begin
						lane_ctl.div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_DIV: begin
				if (lane_busy == '0) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- ring pointers and walk control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= '0;
			fill_q      <= '0;
			last_est_q  <= '0;
			out_valid_q <= 1'b0;
			issued_q    <= '0;
			rd_pend_s1  <= 1'b0;
			stop_q      <= 1'b0;
			n_q         <= '0;
		end else begin
			if (ram_we) begin
				ws_q <= (ws_q == AW'(DEPTH - 1)) ? '0 : ws_q + 1'b1;
				if (fill_q != CNT_W'(DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end

			if (accept) begin
				issued_q   <= '0;
				rd_pend_s1 <= 1'b0;
				stop_q     <= 1'b0;
				n_q        <= '0;
			end else begin
				rd_pend_s1 <= issue;
				if (issue) begin
					issued_q <= issued_q + 1'b1;
				end
				if (hit) begin
					stop_q <= 1'b1;
				end
				if (take) begin
					n_q <= n_q + 1'b1;
				end
			end

			if (load_out && est_ok) begin
				last_est_q <= now_q;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Read pointer starts at the newest slot and steps toward older ones.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			now_q    <= timestamp;
			rd_ptr_q <= (ws_q == '0) ? AW'(DEPTH - 1) : ws_q - 1'b1;
		end else if (issue) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? AW'(DEPTH - 1) : rd_ptr_q - 1'b1;
		end
	end

	// ---------------- axis lanes ----------------
	for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
		tsra_lane #(
			.DEPTH (DEPTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl),
			.sample (rd_word[g*SAMPLE_W +: SAMPLE_W]),
			.count  (n_q),
			.busy   (lane_busy[g]),
			.avg    (lane_avg[g])
		);
	end

	// ---------------- merge into the output register ----------------
	// Push or an estimate that visited nothing reports zeros and keeps the
	// previous estimate time.
	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_x         <= est_ok ? lane_avg[0] : '0;
			avg_y         <= est_ok ? lane_avg[1] : '0;
			avg_z         <= est_ok ? lane_avg[2] : '0;
			samples_used  <= est_ok ? USED_W'(n_q) : '0;
			updated       <= est_ok;
			estimate_time <= est_ok ? now_q : last_est_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/tsra_ram.sv -----
// ----------------------------------------------------------------------------
// tsra_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/tsra_lane.sv -----
// ----------------------------------------------------------------------------
// tsra_lane: one axis of the averager
// Accumulates samples, then divides the sum by the count one bit per cycle
// (restoring division on the magnitude, sign applied at the end).
// ----------------------------------------------------------------------------
module tsra_lane #(
	parameter int DEPTH = 16,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tsra_pkg::lane_ctl_t                 ctl,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] sample,
	input  logic [CNT_W-1:0]                    count,
	output logic                                busy,
	output logic signed [tsra_pkg::SAMPLE_W-1:0] avg
);

	import tsra_pkg::*;

	localparam int SUM_W  = SAMPLE_W + $clog2(DEPTH) + 1;
	localparam int STEP_W = $clog2(SUM_W + 1);

	logic signed [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q;
	logic [STEP_W-1:0]       step_q;
	logic                    neg_q;
	logic                    busy_q;

	logic [CNT_W:0]   trial;
	logic             fits;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] quo_signed;

	always_comb begin
		trial      = {rem_q, quo_q[SUM_W-1]};
		fits       = trial >= {1'b0, count};
		mag        = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
		quo_signed = neg_q ? SUM_W'(-quo_q) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (ctl.div_start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (ctl.accum) begin
			acc_q <= acc_q + SUM_W'(sample);
		end
		if (ctl.div_start) begin
			quo_q <= mag;
			neg_q <= acc_q[SUM_W-1];
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? CNT_W'(trial - {1'b0, count}) : trial[CNT_W-1:0];
		end
	end

	assign busy = busy_q;
	// quotient magnitude never exceeds the sample range
	assign avg  = SAMPLE_W'(quo_signed);

endmodule

// ----- dv/timestamped_sample_ring_average_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamped_sample_ring_average_checker: result predictor and comparator
// Watches both channels of the ring averager. Every accepted input transaction
// runs through a local copy of the sample ring to form the expected result.
// Every accepted result is compared field by field with the oldest expected
// result. Hands failure count, outstanding count and coverage counts to the top.
// ----------------------------------------------------------------------------
module timestamped_sample_ring_average_checker #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic                                 op,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] mag_x,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] mag_y,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] mag_z,
	input  logic [tsra_pkg::TIME_W-1:0]          timestamp,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] avg_x,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] avg_y,
	input  logic signed [tsra_pkg::SAMPLE_W-1:0] avg_z,
	input  logic [tsra_pkg::USED_W-1:0]          samples_used,
	input  logic                                 updated,
	input  logic [tsra_pkg::TIME_W-1:0]          estimate_time,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   pushes_seen,
	output int                                   estimates_seen,
	output int                                   averages_formed,
	output int                                   full_ring_walks
);
	import tsra_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] ax;
		logic [SAMPLE_W-1:0] ay;
		logic [SAMPLE_W-1:0] az;
		logic [USED_W-1:0]   used;
		logic                upd;
		logic [TIME_W-1:0]   est_t;
	} avg_result_t;

	logic [SAMPLE_W-1:0] ring_x [DEPTH];
	logic [SAMPLE_W-1:0] ring_y [DEPTH];
	logic [SAMPLE_W-1:0] ring_z [DEPTH];
	logic [TIME_W-1:0]   ring_t [DEPTH];
	int unsigned         next_slot;
	int unsigned         filled;
	logic [TIME_W-1:0]   last_avg_t;
	avg_result_t         expected_averages [$];

	function automatic avg_result_t predict_ring_average(
		logic                op_i,
		logic [SAMPLE_W-1:0] x,
		logic [SAMPLE_W-1:0] y,
		logic [SAMPLE_W-1:0] z,
		logic [TIME_W-1:0]   now
	);
		avg_result_t r;
		longint      sx;
		longint      sy;
		longint      sz;
		int unsigned n;
		int unsigned slot;
		int          k;
		r  = '0;
		sx = 0;
		sy = 0;
		sz = 0;
		n  = 0;
		if (op_i == OP_PUSH) begin
			ring_x[next_slot] = x;
			ring_y[next_slot] = y;
			ring_z[next_slot] = z;
			ring_t[next_slot] = now;
			next_slot = (next_slot + 1) % DEPTH;
			if (filled < DEPTH)
				filled++;
		end else begin
			// newest first, stop at the first sample older than the last estimate
			for (k = 0; k < filled; k++) begin
				slot = (next_slot + DEPTH - 1 - k) % DEPTH;
				if (ring_t[slot] < last_avg_t)
					break;
				sx += $signed(ring_x[slot]);
				sy += $signed(ring_y[slot]);
				sz += $signed(ring_z[slot]);
				n++;
			end
			if (n > 0) begin
				// signed longint division truncates toward zero
				r.ax       = SAMPLE_W'(sx / longint'(n));
				r.ay       = SAMPLE_W'(sy / longint'(n));
				r.az       = SAMPLE_W'(sz / longint'(n));
				r.used     = USED_W'(n);
				r.upd      = 1'b1;
				last_avg_t = now;
			end
		end
		r.est_t = last_avg_t;
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ERROR %s", $time, what);
		fail_count++;
	endtask

	task automatic check_field(string name, longint got, longint want);
		if (got != want)
			report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		avg_result_t want;
		if (!arst_n) begin
			next_slot       = 0;
			filled          = 0;
			last_avg_t      = '0;
			fail_count      = 0;
			pushes_seen     = 0;
			estimates_seen  = 0;
			averages_formed = 0;
			full_ring_walks = 0;
			expected_averages.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_averages.push_back(
					predict_ring_average(op, mag_x, mag_y, mag_z, timestamp));
				if (op == OP_PUSH)
					pushes_seen++;
				else
					estimates_seen++;
			end
			if (out_valid && !out_stall) begin
				if (expected_averages.size() == 0) begin
					report_mismatch("result transaction with no expected result waiting");
				end else begin
					want = expected_averages.pop_front();
					check_field("avg_x", $signed(avg_x), $signed(want.ax));
					check_field("avg_y", $signed(avg_y), $signed(want.ay));
					check_field("avg_z", $signed(avg_z), $signed(want.az));
					check_field("samples_used", samples_used, want.used);
					check_field("updated", updated, want.upd);
					check_field("estimate_time", estimate_time, want.est_t);
					if (want.upd)
						averages_formed++;
					if (want.used == USED_W'(DEPTH))
						full_ring_walks++;
				end
			end
			pending <= expected_averages.size();
		end
	end

endmodule

// ----- dv/tb_timestamped_sample_ring_average_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamped_sample_ring_average_unit: testbench top for the ring averager
// Drives push and estimate transactions with random gaps and random result
// stalls, including two long result hold-offs that back the block up. A
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_timestamped_sample_ring_average_unit;
	import tsra_pkg::*;

	localparam int DEPTH          = 16;
	localparam int ITEMS          = 1850;
	localparam int GAP_MAX        = 17;
	// long result hold-off; block fills after two transactions and stalls input
	localparam int HOLD_CYCLES    = 250;
	// worst correct idle stretch is a hold-off plus one full-ring estimate
	localparam int WATCHDOG_LIMIT = 3000;
	// margin for a full-ring estimate plus a receiver stall
	localparam int DRAIN_CYCLES   = 80;

	localparam logic [SAMPLE_W-1:0] AXIS_MIN = 16'h8000;
	localparam logic [SAMPLE_W-1:0] AXIS_MAX = 16'h7FFF;
	localparam logic [TIME_W-1:0]   TIME_MAX = 32'hFFFF_FFFF;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic                       op;
	logic signed [SAMPLE_W-1:0] mag_x;
	logic signed [SAMPLE_W-1:0] mag_y;
	logic signed [SAMPLE_W-1:0] mag_z;
	logic [TIME_W-1:0]          timestamp;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] avg_x;
	logic signed [SAMPLE_W-1:0] avg_y;
	logic signed [SAMPLE_W-1:0] avg_z;
	logic [USED_W-1:0]          samples_used;
	logic                       updated;
	logic [TIME_W-1:0]          estimate_time;

	int fail_count;
	int pending;
	int pushes_seen;
	int estimates_seen;
	int averages_formed;
	int full_ring_walks;

	int                items_sent;
	int                idle_cycles;
	bit                send_burst;     // sender runs back to back while set
	bit                recv_burst;     // receiver stalls only for a requested hold-off while set
	bit                hold_request;   // asks the receiver for one long hold-off
	bit                stale_history;  // noise may have moved the last estimate time
	logic [TIME_W-1:0] stamp_cursor;   // running sensor clock for clean sequences
	logic [TIME_W-1:0] est_mark;       // time of the last clean estimate

	timestamped_sample_ring_average_unit #(.DEPTH(DEPTH)) DUT (.*);

	timestamped_sample_ring_average_checker #(.DEPTH(DEPTH)) u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: any accepted transaction on either side resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: %0d cycles without a transaction, %0d results outstanding",
					idle_cycles, pending);
				$display("tb_timestamped_sample_ring_average_unit NOT OK");
				$finish;
			end
		end
	end

	// Result side: per result a random stall, with stretches of no stall and
	// the odd long hold-off requested by the stimulus process.
	initial begin : result_sink
		int hold;
		out_stall = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = !recv_burst;
			hold = recv_burst ? 0 : $urandom_range(0, GAP_MAX);
			if (hold_request) begin
				hold         = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Mostly random samples, with the axis extremes and the values around zero
	// showing up often enough to hit truncation of negative averages.
	function automatic logic [SAMPLE_W-1:0] pick_axis();
		case ($urandom_range(0, 7))
			0: return AXIS_MIN;
			1: return AXIS_MAX;
			2: return '1;
			3: return '0;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// One input transaction: optional random gap, then hold valid until taken.
	// Called at a rising edge, returns at the edge that accepted the item.
	task automatic send_item(
		logic                op_i,
		logic [SAMPLE_W-1:0] x,
		logic [SAMPLE_W-1:0] y,
		logic [SAMPLE_W-1:0] z,
		logic [TIME_W-1:0]   ts
	);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		op        <= op_i;
		mag_x     <= x;
		mag_y     <= y;
		mag_z     <= z;
		timestamp <= ts;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (items_sent == 600 || items_sent == 1300)
			hold_request = 1'b1;
	endtask

	// A clean window: a burst of pushes on a rising clock, then an estimate.
	// Long bursts wrap the ring; a few pushes predate the last estimate so the
	// walk stops partway; an extra estimate right after sees at most the samples stamped at the last estimate time.
	task automatic run_window();
		int                pushes;
		logic [TIME_W-1:0] ts;
		// a noise estimate may have left the last estimate time anywhere;
		// a sample at the top of the time range is always visited, so one
		// push plus an estimate pulls it back to the cursor
		if (stale_history) begin
			send_item(OP_PUSH, pick_axis(), pick_axis(), pick_axis(), TIME_MAX);
			send_item(OP_ESTIMATE, pick_axis(), pick_axis(), pick_axis(), stamp_cursor);
			est_mark      = stamp_cursor;
			stale_history = 1'b0;
		end
		pushes = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
		repeat (pushes) begin
			stamp_cursor += $urandom_range(0, 3);
			if ($urandom_range(0, 11) == 0 && est_mark != '0)
				ts = est_mark - 1;
			else
				ts = stamp_cursor;
			send_item(OP_PUSH, pick_axis(), pick_axis(), pick_axis(), ts);
		end
		stamp_cursor += $urandom_range(0, 3);
		send_item(OP_ESTIMATE, pick_axis(), pick_axis(), pick_axis(), stamp_cursor);
		est_mark = stamp_cursor;
		if ($urandom_range(0, 5) == 0)
			send_item(OP_ESTIMATE, pick_axis(), pick_axis(), pick_axis(),
				stamp_cursor + $urandom_range(0, 3));
	endtask

	// Noise: fully random operation, samples and time, across all 32 bits.
	task automatic inject_noise();
		repeat ($urandom_range(1, 4))
			send_item(logic'($urandom_range(0, 1)), pick_axis(), pick_axis(), pick_axis(),
				$urandom());
		stale_history = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		op            = OP_PUSH;
		mag_x         = '0;
		mag_y         = '0;
		mag_z         = '0;
		timestamp     = '0;
		items_sent    = 0;
		idle_cycles   = 0;
		send_burst    = 1'b0;
		recv_burst    = 1'b0;
		hold_request  = 1'b0;
		stale_history = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// estimate on an empty ring: nothing visited
		send_item(OP_ESTIMATE, '0, '0, '0, '0);
		// sample stamped exactly at the last estimate time counts as recent
		send_item(OP_PUSH, AXIS_MAX, AXIS_MIN, 16'h0001, 32'd0);
		send_item(OP_PUSH, AXIS_MIN, AXIS_MAX, 16'hFFFF, 32'd5);
		send_item(OP_PUSH, AXIS_MAX, AXIS_MAX, 16'hFFFD, 32'd5);
		send_item(OP_ESTIMATE, '0, '0, '0, 32'd10);
		// newest sample older than the last estimate: nothing visited
		send_item(OP_ESTIMATE, '0, '0, '0, 32'd11);
		// walk stops at the sample stamped 9; negative odd sums truncate
		send_item(OP_PUSH, 16'h0003, 16'h0003, 16'h0003, 32'd9);
		send_item(OP_PUSH, 16'hFFF9, 16'h0007, AXIS_MIN, 32'd10);
		send_item(OP_PUSH, 16'hFFFC, AXIS_MIN, 16'h8001, 32'd12);
		send_item(OP_ESTIMATE, '0, '0, '0, 32'd20);
		// top of the time range
		send_item(OP_PUSH, AXIS_MAX, AXIS_MAX, AXIS_MAX, TIME_MAX);
		send_item(OP_ESTIMATE, AXIS_MAX, AXIS_MAX, AXIS_MAX, TIME_MAX);
		// estimate at time zero still visits a sample at the maximum time
		send_item(OP_PUSH, AXIS_MIN, AXIS_MIN, AXIS_MIN, TIME_MAX);
		send_item(OP_ESTIMATE, AXIS_MIN, AXIS_MIN, AXIS_MIN, '0);
		// every filled entry is recent: walk covers the whole partial ring
		send_item(OP_PUSH, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd1);
		send_item(OP_PUSH, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd2);
		send_item(OP_PUSH, AXIS_MIN, AXIS_MIN, AXIS_MIN, 32'd3);
		send_item(OP_ESTIMATE, '0, '0, '0, 32'd3);
		est_mark = 32'd3;

		// --- random ---
		// cursor starts low enough that the run never wraps the sensor clock
		stamp_cursor = $urandom_range(3, 32'hF000_0000);
		while (items_sent < ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				inject_noise();
			else
				run_window();
		end
		in_valid <= 1'b0;

		// let the checker see the last accept, then drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pushes and %0d estimates; %0d formed an average,",
			pushes_seen, estimates_seen, averages_formed);
		$display("%0d of them over a full ring, with one long result hold-off twice",
			full_ring_walks);
		if (fail_count == 0 && pending == 0) begin
			$display("tb_timestamped_sample_ring_average_unit OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, pending);
			$display("tb_timestamped_sample_ring_average_unit NOT OK");
		end
		$finish;
	end

endmodule
